### rtl/nir_pkg.sv
// Package for the NEC infrared frame decoder: widths, register indexes,
// reset values and the shared item and match types. No dependencies.
package nir_pkg;

    localparam int DUR_W      = 15;
    localparam int TOL_W      = 7;
    localparam int LIM_W      = DUR_W + TOL_W;
    localparam int CNT_W      = 6;
    localparam int FRAME_BITS = 32;
    localparam int NUM_DUR    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;

    localparam logic [CNT_W-1:0]  FULL_ITEMS = CNT_W'(34);
    localparam logic [CNT_W-1:0]  LAST_BIT   = CNT_W'(FRAME_BITS);
    localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;

    typedef logic [DUR_W-1:0] t_dur;
    typedef logic [TOL_W-1:0] t_tol;
    typedef logic [LIM_W-1:0] t_lim;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_MARK  = 3'd0,
        CFG_LEADER_SPACE = 3'd1,
        CFG_REPEAT_SPACE = 3'd2,
        CFG_BIT_MARK     = 3'd3,
        CFG_ONE_SPACE    = 3'd4,
        CFG_ZERO_SPACE   = 3'd5,
        CFG_TOLERANCE    = 3'd6
    } t_cfg_idx;

    localparam t_tol TOL_RST = 7'd25;

    localparam t_dur DUR_RST [NUM_DUR] = '{
        15'd9000, 15'd4500, 15'd2250, 15'd560, 15'd1690, 15'd560
    };

    localparam t_lim LIM_RST [NUM_DUR] = '{
        22'(9000 * 25), 22'(4500 * 25), 22'(2250 * 25),
        22'(560 * 25), 22'(1690 * 25), 22'(560 * 25)
    };

    typedef struct packed {
        t_dur mark_time;
        t_dur space_time;
        logic last_item;
    } t_item;

    typedef struct packed {
        logic lead_mark;
        logic data_mark;
        logic rpt_space;
        logic lead_space;
        logic hi_space;
        logic lo_space;
    } t_match;

endpackage

### rtl/nir_if.sv
// Handshake channels of the NEC infrared frame decoder: captured items in,
// decoded results out. Depends on nir_pkg.
interface nir_item_if;
    import nir_pkg::*;

    logic valid;
    logic ready;
    t_dur mark_time;
    t_dur space_time;
    logic last_item;

    modport source (output valid, output mark_time, output space_time,
                    output last_item, input ready);
    modport sink   (input valid, input mark_time, input space_time,
                    input last_item, output ready);
endinterface

interface nir_result_if;
    import nir_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic                is_repeat;
    logic                is_extended;
    logic [ADDR_W-1:0]   address;
    logic [BYTE_W-1:0]   command;
    logic [FRAME_BITS-1:0] raw_word;

    modport source (output valid, output ok, output is_repeat, output is_extended,
                    output address, output command, output raw_word, input ready);
    modport sink   (input valid, input ok, input is_repeat, input is_extended,
                    input address, input command, input raw_word, output ready);
endinterface

### rtl/nir_match.sv
// Duration window compares for one captured item against all six expected
// durations, using precomputed tolerance limits. Depends on nir_pkg.
module nir_match (
    input  nir_pkg::t_item  i_item,
    input  nir_pkg::t_dur   i_dur [nir_pkg::NUM_DUR],
    input  nir_pkg::t_lim   i_lim [nir_pkg::NUM_DUR],
    output nir_pkg::t_match o_match
);
    import nir_pkg::*;

    function automatic logic near(input t_dur got, input t_dur want, input t_lim lim);
        t_dur diff;
        t_lim diff_x100;
        diff      = (got > want) ? t_dur'(got - want) : t_dur'(want - got);
        diff_x100 = (t_lim'(diff) << 6) + (t_lim'(diff) << 5) + (t_lim'(diff) << 2);
        return diff_x100 <= lim;
    endfunction

    assign o_match.lead_mark  = near(i_item.mark_time, i_dur[CFG_LEADER_MARK],
                                     i_lim[CFG_LEADER_MARK]);
    assign o_match.data_mark  = near(i_item.mark_time, i_dur[CFG_BIT_MARK],
                                     i_lim[CFG_BIT_MARK]);
    assign o_match.rpt_space  = near(i_item.space_time, i_dur[CFG_REPEAT_SPACE],
                                     i_lim[CFG_REPEAT_SPACE]);
    assign o_match.lead_space = near(i_item.space_time, i_dur[CFG_LEADER_SPACE],
                                     i_lim[CFG_LEADER_SPACE]);
    assign o_match.hi_space   = near(i_item.space_time, i_dur[CFG_ONE_SPACE],
                                     i_lim[CFG_ONE_SPACE]);
    assign o_match.lo_space   = near(i_item.space_time, i_dur[CFG_ZERO_SPACE],
                                     i_lim[CFG_ZERO_SPACE]);

endmodule

### rtl/nec_ir_frame_decoder_top.sv
// Top level of the NEC / extended NEC infrared frame decoder: config registers,
// three-stage item pipeline and result register. Depends on nir_pkg, nir_if,
// nir_match.
//
//  channel   direction  handshake          payload
//  i_item    in         valid/ready        mark_time, space_time, last_item
//  o_result  out        valid/ready        ok, is_repeat, is_extended, address,
//                                          command, raw_word
//  i_cfg_*   in         write enable only  register index, 15-bit data
//
// One item per cycle sustained unless a last item waits on a stalled result; a request
// passes the input register and match register before the frame state and result register.
// Tolerance limits are multiplied out in the config write cycle.
// Synchronous active-low reset clears valids and frame state; config returns
// to defaults. A stalled result holds the pipeline only when a last item waits.
module nec_ir_frame_decoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    nir_item_if.sink                       i_item,
    nir_result_if.source                   o_result,
    input  logic                           i_cfg_we,
    input  logic [nir_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nir_pkg::DUR_W-1:0]      i_cfg_data
);
    import nir_pkg::*;

    t_dur r_dur [NUM_DUR];
    t_lim r_lim [NUM_DUR];
    t_tol r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur <= DUR_RST;
            r_lim <= LIM_RST;
            r_tol <= TOL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LEADER_MARK, CFG_LEADER_SPACE, CFG_REPEAT_SPACE,
                CFG_BIT_MARK, CFG_ONE_SPACE, CFG_ZERO_SPACE: begin
                    r_dur[i_cfg_idx] <= i_cfg_data;
                    r_lim[i_cfg_idx] <= t_lim'(i_cfg_data) * t_lim'(r_tol);
                end
                CFG_TOLERANCE: begin
                    r_tol <= i_cfg_data[TOL_W-1:0];
                    for (int k = 0; k < NUM_DUR; k++) begin
                        r_lim[k] <= t_lim'(r_dur[k]) * t_lim'(i_cfg_data[TOL_W-1:0]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    logic   r_a_valid;
    t_item  r_a_item;
    logic   r_b_valid;
    logic   r_b_last;
    t_match r_b_match;
    t_match w_match;

    t_cnt              r_cnt;
    logic [FRAME_BITS-1:0] r_shift;
    logic              r_fail;
    logic              r_rep;

    logic                  r_o_valid;
    logic                  r_o_ok;
    logic                  r_o_rep;
    logic                  r_o_ext;
    logic [ADDR_W-1:0]     r_o_addr;
    logic [BYTE_W-1:0]     r_o_cmd;
    logic [FRAME_BITS-1:0] r_o_raw;

    logic w_b_adv;
    logic w_a_adv;
    logic w_in_req;

    assign w_b_adv  = r_b_valid && !(r_b_last && r_o_valid && !o_result.ready);
    assign w_a_adv  = r_a_valid && (!r_b_valid || w_b_adv);
    assign i_item.ready = !r_a_valid || w_a_adv;
    assign w_in_req = i_item.valid && i_item.ready;

    nir_match u_match (
        .i_item  (r_a_item),
        .i_dur   (r_dur),
        .i_lim   (r_lim),
        .o_match (w_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_in_req) begin
                r_a_valid <= 1'b1;
            end else if (w_a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_adv) begin
                r_b_valid <= 1'b1;
            end else if (w_b_adv) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_req) begin
            r_a_item.mark_time  <= i_item.mark_time;
            r_a_item.space_time <= i_item.space_time;
            r_a_item.last_item  <= i_item.last_item;
        end
        if (w_a_adv) begin
            r_b_match <= w_match;
            r_b_last  <= r_a_item.last_item;
        end
    end

    t_cnt                  n_cnt;
    logic [FRAME_BITS-1:0] n_shift;
    logic                  n_fail;
    logic                  n_rep;
    logic [4:0]            w_bitpos;
    logic                  w_ok;
    logic                  w_ext;
    logic [BYTE_W-1:0]     w_alo;
    logic [BYTE_W-1:0]     w_ahi;
    logic [BYTE_W-1:0]     w_cmd;
    logic [BYTE_W-1:0]     w_cmd_inv;

    assign w_bitpos = 5'(r_cnt - t_cnt'(1));

    always_comb begin
        n_shift = r_shift;
        n_fail  = r_fail;
        n_rep   = r_rep;
        priority if (r_cnt == '0) begin
            if (!r_b_match.lead_mark) begin
                n_fail = 1'b1;
            end else if (r_b_match.rpt_space) begin
                n_rep = 1'b1;
            end else if (!r_b_match.lead_space) begin
                n_fail = 1'b1;
            end
        end else if (r_rep) begin
            if (r_cnt == t_cnt'(1) && !r_b_match.data_mark) begin
                n_fail = 1'b1;
            end
        end else if (r_cnt <= LAST_BIT) begin
            if (!r_b_match.data_mark) begin
                n_fail = 1'b1;
            end else if (r_b_match.hi_space) begin
                n_shift = r_shift | (FRAME_BITS'(1) << w_bitpos);
            end else if (!r_b_match.lo_space) begin
                n_fail = 1'b1;
            end
        end else begin
        end
        n_cnt = (r_cnt < FULL_ITEMS) ? t_cnt'(r_cnt + t_cnt'(1)) : r_cnt;
    end

    assign w_alo     = n_shift[7:0];
    assign w_ahi     = n_shift[15:8];
    assign w_cmd     = n_shift[23:16];
    assign w_cmd_inv = n_shift[31:24];

    always_comb begin
        w_ok  = 1'b0;
        w_ext = 1'b0;
        if (n_cnt >= t_cnt'(2) && !n_fail) begin
            if (n_rep) begin
                w_ok = 1'b1;
            end else if (n_cnt >= FULL_ITEMS && (w_cmd ^ w_cmd_inv) == BYTE_MASK) begin
                w_ok  = 1'b1;
                w_ext = (w_alo ^ w_ahi) != BYTE_MASK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_shift   <= '0;
            r_fail    <= 1'b0;
            r_rep     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_b_adv) begin
                if (r_b_last) begin
                    r_cnt   <= '0;
                    r_shift <= '0;
                    r_fail  <= 1'b0;
                    r_rep   <= 1'b0;
                end else begin
                    r_cnt   <= n_cnt;
                    r_shift <= n_shift;
                    r_fail  <= n_fail;
                    r_rep   <= n_rep;
                end
            end
            if (w_b_adv && r_b_last) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_adv && r_b_last) begin
            r_o_ok   <= w_ok;
            r_o_rep  <= w_ok && n_rep;
            r_o_ext  <= w_ok && !n_rep && w_ext;
            r_o_cmd  <= (w_ok && !n_rep) ? w_cmd : '0;
            r_o_raw  <= (w_ok && !n_rep) ? n_shift : '0;
            if (!w_ok || n_rep) begin
                r_o_addr <= '0;
            end else if (w_ext) begin
                r_o_addr <= {w_ahi, w_alo};
            end else begin
                r_o_addr <= {8'h00, w_alo};
            end
        end
    end

    assign o_result.valid       = r_o_valid;
    assign o_result.ok          = r_o_ok;
    assign o_result.is_repeat   = r_o_rep;
    assign o_result.is_extended = r_o_ext;
    assign o_result.address     = r_o_addr;
    assign o_result.command     = r_o_cmd;
    assign o_result.raw_word    = r_o_raw;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_ITEMS)
        else $error("item count beyond saturation");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_adv && r_b_last) |=> (r_cnt == '0 && !r_fail && !r_rep && r_shift == '0))
        else $error("frame state not cleared after last item");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_ok) |->
            (!r_o_rep && !r_o_ext && r_o_addr == '0 && r_o_cmd == '0 && r_o_raw == '0))
        else $error("failed result carries nonzero fields");

    a_repeat_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_rep) |-> (r_o_ok && !r_o_ext && r_o_raw == '0))
        else $error("repeat result with data fields");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_result.ready) |=> r_o_valid)
        else $error("pending result dropped");

endmodule

### dv/tb_nec_ir_frame_decoder_top.sv
// Testbench for nec_ir_frame_decoder_top: drives captured mark/space items and
// register writes, predicts every decoded frame and checks each result.
// Depends on nir_pkg, nir_if and the decoder RTL.
module tb_nec_ir_frame_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nir_pkg::*;

    typedef struct packed {
        logic                  ok;
        logic                  is_repeat;
        logic                  is_extended;
        logic [ADDR_W-1:0]     address;
        logic [BYTE_W-1:0]     command;
        logic [FRAME_BITS-1:0] raw_word;
    } t_decode;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_ITEM,
        FLAW_SHORT,
        FLAW_EXTRA,
        FLAW_WILD_STOP
    } t_flaw;

    typedef enum int {
        WORD_STANDARD,
        WORD_EXTENDED,
        WORD_BAD_COMMAND
    } t_word_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    t_dur                 cfg_data;

    nir_item_if   item_ch ();
    nir_result_if result_ch ();

    nec_ir_frame_decoder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    t_dur            dur_reg [NUM_DUR];
    t_tol            tol_reg;
    int unsigned     cap_count;
    logic [31:0]     cap_bits;
    bit              cap_failed;
    bit              cap_repeat;
    t_decode         pending_decodes [$];
    int              error_count;
    bit              no_gaps;

    function automatic bit within_tol(int unsigned got, int unsigned want);
        longint unsigned diff;
        diff = (got > want) ? longint'(got - want) : longint'(want - got);
        return diff * 100 <= longint'(want) * longint'(tol_reg);
    endfunction

    function automatic void decode_item(t_item it);
        t_decode     res;
        logic [7:0]  alo, ahi, cmd, cmdn;
        if (cap_count == 0) begin
            if (!within_tol(it.mark_time, dur_reg[CFG_LEADER_MARK]))
                cap_failed = 1'b1;
            else if (within_tol(it.space_time, dur_reg[CFG_REPEAT_SPACE]))
                cap_repeat = 1'b1;
            else if (!within_tol(it.space_time, dur_reg[CFG_LEADER_SPACE]))
                cap_failed = 1'b1;
        end else if (cap_repeat) begin
            if (cap_count == 1 && !within_tol(it.mark_time, dur_reg[CFG_BIT_MARK]))
                cap_failed = 1'b1;
        end else if (cap_count <= FRAME_BITS) begin
            if (!within_tol(it.mark_time, dur_reg[CFG_BIT_MARK]))
                cap_failed = 1'b1;
            else if (within_tol(it.space_time, dur_reg[CFG_ONE_SPACE]))
                cap_bits[cap_count - 1] = 1'b1;
            else if (!within_tol(it.space_time, dur_reg[CFG_ZERO_SPACE]))
                cap_failed = 1'b1;
        end
        if (cap_count < FULL_ITEMS)
            cap_count++;
        if (!it.last_item)
            return;
        res = '0;
        if (cap_count >= 2 && !cap_failed) begin
            if (cap_repeat) begin
                res.ok        = 1'b1;
                res.is_repeat = 1'b1;
            end else if (cap_count >= FULL_ITEMS) begin
                {cmdn, cmd, ahi, alo} = cap_bits;
                if ((cmd ^ cmdn) == BYTE_MASK) begin
                    res.ok       = 1'b1;
                    res.command  = cmd;
                    res.raw_word = cap_bits;
                    if ((alo ^ ahi) == BYTE_MASK) begin
                        res.address = {8'h00, alo};
                    end else begin
                        res.is_extended = 1'b1;
                        res.address     = {ahi, alo};
                    end
                end
            end
        end
        pending_decodes = {pending_decodes, res};
        cap_count  = 0;
        cap_bits   = '0;
        cap_failed = 1'b0;
        cap_repeat = 1'b0;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        error_count++;
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    endtask

    task automatic check_decode();
        t_decode want;
        if (pending_decodes.size() == 0) begin
            report_mismatch("unrequested result raw_word", result_ch.raw_word, 0);
            return;
        end
        want = pending_decodes.pop_front();
        if (result_ch.ok !== want.ok)
            report_mismatch("ok", result_ch.ok, want.ok);
        if (result_ch.is_repeat !== want.is_repeat)
            report_mismatch("is_repeat", result_ch.is_repeat, want.is_repeat);
        if (result_ch.is_extended !== want.is_extended)
            report_mismatch("is_extended", result_ch.is_extended, want.is_extended);
        if (result_ch.address !== want.address)
            report_mismatch("address", result_ch.address, want.address);
        if (result_ch.command !== want.command)
            report_mismatch("command", result_ch.command, want.command);
        if (result_ch.raw_word !== want.raw_word)
            report_mismatch("raw_word", result_ch.raw_word, want.raw_word);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            check_decode();
    end

    initial begin : result_sink
        int stall;
        result_ch.ready = 1'b0;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 19);
            @(negedge i_clk);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (result_ch.valid !== 1'b1) @(posedge i_clk);
        end
    end

    task automatic send_item(t_dur mark, t_dur space, logic last);
        int    gap;
        t_item it;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        it  = '{mark_time: mark, space_time: space, last_item: last};
        if (gap > 0) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_ch.valid      <= 1'b1;
        item_ch.mark_time  <= mark;
        item_ch.space_time <= space;
        item_ch.last_item  <= last;
        @(posedge i_clk);
        while (item_ch.ready !== 1'b1) @(posedge i_clk);
        decode_item(it);
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
    endtask

    // drain every pending request, then let the pipeline empty
    task automatic settle_decoder();
        hold_input();
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, int unsigned value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= t_dur'(value);
        if (idx == CFG_TOLERANCE)
            tol_reg = t_tol'(value);
        else
            dur_reg[idx] = t_dur'(value);
    endtask

    task automatic apply_settings(int unsigned lm, int unsigned ls, int unsigned rs,
                                  int unsigned bm, int unsigned os, int unsigned zs,
                                  int unsigned tol);
        settle_decoder();
        set_reg(CFG_LEADER_MARK, lm);
        set_reg(CFG_LEADER_SPACE, ls);
        set_reg(CFG_REPEAT_SPACE, rs);
        set_reg(CFG_BIT_MARK, bm);
        set_reg(CFG_ONE_SPACE, os);
        set_reg(CFG_ZERO_SPACE, zs);
        set_reg(CFG_TOLERANCE, tol);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int unsigned slack(t_dur want);
        int unsigned w;
        w = want;
        return (w * tol_reg) / 100;
    endfunction

    function automatic t_dur hit_dur(t_dur want);
        int unsigned w, s, d;
        w = want;
        s = slack(want);
        d = ($urandom_range(0, 3) == 0) ? s : $urandom_range(0, s);
        if ($urandom_range(0, 1) == 1 && w + d <= 32767)
            return t_dur'(w + d);
        if (w >= d)
            return t_dur'(w - d);
        if (w + d <= 32767)
            return t_dur'(w + d);
        return want;
    endfunction

    function automatic t_dur miss_dur(t_dur want);
        int unsigned w, d;
        w = want;
        d = slack(want) + 1 + (($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 2000));
        if ($urandom_range(0, 1) == 1 && w >= d)
            return t_dur'(w - d);
        if (w + d <= 32767)
            return t_dur'(w + d);
        if (w >= d)
            return t_dur'(w - d);
        return t_dur'($urandom);
    endfunction

    function automatic logic [31:0] make_word(t_word_kind kind);
        logic [7:0] alo, ahi, cmd, cmdn;
        alo  = 8'($urandom);
        cmd  = 8'($urandom);
        ahi  = ~alo;
        cmdn = ~cmd;
        if (kind == WORD_EXTENDED) begin
            ahi = 8'($urandom);
            if ((ahi ^ alo) == BYTE_MASK)
                ahi ^= 8'h01;
        end
        if (kind == WORD_BAD_COMMAND) begin
            cmdn = 8'($urandom);
            if ((cmdn ^ cmd) == BYTE_MASK)
                cmdn ^= 8'h80;
        end
        return {cmdn, cmd, ahi, alo};
    endfunction

    task automatic send_frame(logic [31:0] word, t_flaw flaw);
        int   stop_at, bad_at, extras;
        t_dur m, s;
        stop_at = (flaw == FLAW_SHORT) ? $urandom_range(1, 32) : 33;
        bad_at  = (flaw == FLAW_BAD_ITEM) ? $urandom_range(0, 32) : -1;
        extras  = (flaw == FLAW_EXTRA) ? $urandom_range(1, 4) : 0;
        for (int idx = 0; idx <= stop_at; idx++) begin
            if (idx == 0) begin
                m = hit_dur(dur_reg[CFG_LEADER_MARK]);
                s = hit_dur(dur_reg[CFG_LEADER_SPACE]);
                if (bad_at == 0) begin
                    if ($urandom_range(0, 1) == 1)
                        m = miss_dur(dur_reg[CFG_LEADER_MARK]);
                    else
                        s = miss_dur(dur_reg[CFG_LEADER_SPACE]);
                end
            end else if (idx <= FRAME_BITS) begin
                m = hit_dur(dur_reg[CFG_BIT_MARK]);
                s = word[idx - 1] ? hit_dur(dur_reg[CFG_ONE_SPACE])
                                  : hit_dur(dur_reg[CFG_ZERO_SPACE]);
                if (bad_at == idx) begin
                    if ($urandom_range(0, 1) == 1)
                        m = miss_dur(dur_reg[CFG_BIT_MARK]);
                    else
                        s = miss_dur(word[idx - 1] ? dur_reg[CFG_ONE_SPACE]
                                                   : dur_reg[CFG_ZERO_SPACE]);
                end
            end else if (flaw == FLAW_WILD_STOP) begin
                m = t_dur'($urandom);
                s = t_dur'($urandom);
            end else begin
                m = hit_dur(dur_reg[CFG_BIT_MARK]);
                s = t_dur'($urandom);
            end
            send_item(m, s, idx == stop_at && extras == 0);
        end
        for (int e = 1; e <= extras; e++)
            send_item(t_dur'($urandom), t_dur'($urandom), e == extras);
    endtask

    task automatic send_repeat(bit bad_mark, int extras);
        send_item(hit_dur(dur_reg[CFG_LEADER_MARK]), hit_dur(dur_reg[CFG_REPEAT_SPACE]), 1'b0);
        send_item(bad_mark ? miss_dur(dur_reg[CFG_BIT_MARK]) : hit_dur(dur_reg[CFG_BIT_MARK]),
                  t_dur'($urandom), extras == 0);
        for (int e = 1; e <= extras; e++)
            send_item(t_dur'($urandom), t_dur'($urandom), e == extras);
    endtask

    task automatic send_noise(int count);
        for (int n = 1; n <= count; n++)
            send_item(t_dur'($urandom), t_dur'($urandom),
                      n == count || $urandom_range(0, 7) == 0);
    endtask

    task automatic random_capture();
        int         pick;
        t_flaw      flaw;
        t_word_kind kind;
        no_gaps = ($urandom_range(0, 4) == 0);
        pick    = $urandom_range(0, 99);
        if (pick < 70) begin
            pick = $urandom_range(0, 99);
            flaw = (pick < 60) ? FLAW_NONE : (pick < 70) ? FLAW_BAD_ITEM :
                   (pick < 80) ? FLAW_SHORT : (pick < 90) ? FLAW_EXTRA : FLAW_WILD_STOP;
            pick = $urandom_range(0, 99);
            kind = (pick < 50) ? WORD_STANDARD : (pick < 80) ? WORD_EXTENDED
                                                             : WORD_BAD_COMMAND;
            send_frame(make_word(kind), flaw);
        end else if (pick < 90) begin
            send_repeat($urandom_range(0, 4) == 0, $urandom_range(0, 3));
        end else begin
            send_noise($urandom_range(1, 5));
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_directed_captures();
        send_item(15'd9000, 15'd4500, 1'b1);
        send_item(15'd9000, 15'd2250, 1'b0);
        send_item(15'd560, 15'd32767, 1'b1);
        send_item(15'd9000, 15'd2250, 1'b0);
        send_item(15'd2000, 15'd0, 1'b1);
        send_item(15'd8000, 15'd2500, 1'b0);
        send_item(15'd600, 15'd100, 1'b0);
        send_item(15'd0, 15'd32767, 1'b1);
        send_item(15'd5000, 15'd4500, 1'b0);
        send_item(15'd560, 15'd560, 1'b1);
        send_item(15'd9000, 15'd3000, 1'b0);
        send_item(15'd560, 15'd560, 1'b1);
        send_item(15'd0, 15'd0, 1'b1);
        send_item(15'd32767, 15'd32767, 1'b1);
        send_item(15'd9000, 15'd4500, 1'b0);
        repeat (4) send_item(15'd560, 15'd1690, 1'b0);
        send_item(15'd560, 15'd560, 1'b1);
        // tolerance edge: exactly on the window, then one tick past it
        send_item(15'd11250, 15'd2250, 1'b0);
        send_item(15'd560, 15'd0, 1'b1);
        send_item(15'd11251, 15'd2250, 1'b0);
        send_item(15'd560, 15'd0, 1'b1);
    endtask

    task automatic test_default_frames();
        send_frame(make_word(WORD_STANDARD), FLAW_NONE);
        send_frame(make_word(WORD_EXTENDED), FLAW_NONE);
        send_frame(make_word(WORD_BAD_COMMAND), FLAW_NONE);
        repeat (8) random_capture();
    endtask

    task automatic test_setting_sweep();
        int unsigned sweep [6][7] = '{
            '{40, 20, 10, 4, 12, 4, 50},
            '{9000, 4500, 2250, 560, 1690, 560, 0},
            '{32767, 30000, 16000, 1000, 3000, 1000, 10},
            '{9000, 4500, 2250, 560, 1690, 0, 127},
            '{0, 0, 7, 0, 0, 0, 0},
            '{9000, 4500, 2250, 560, 1690, 560, 100}
        };
        foreach (sweep[k]) begin
            apply_settings(sweep[k][0], sweep[k][1], sweep[k][2], sweep[k][3],
                           sweep[k][4], sweep[k][5], sweep[k][6]);
            send_frame(make_word(WORD_STANDARD), FLAW_NONE);
            repeat (2) random_capture();
        end
    endtask

    // one and zero windows overlap: overlapping spaces decode as one
    task automatic test_ambiguous_space();
        apply_settings(9000, 4500, 2250, 560, 600, 560, 25);
        repeat (3) send_frame(make_word(WORD_STANDARD), FLAW_NONE);
    endtask

    task automatic test_noise_items();
        apply_settings(9000, 4500, 2250, 560, 1690, 560, 25);
        send_noise(120);
    endtask

    task automatic test_hold_for_results();
        repeat (4) begin
            random_capture();
            settle_decoder();
        end
    endtask

    task automatic test_random_captures();
        apply_settings(8000, 4000, 2000, 500, 1500, 500, 20);
        repeat (10) random_capture();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        item_ch.valid      = 1'b0;
        item_ch.mark_time  = '0;
        item_ch.space_time = '0;
        item_ch.last_item  = 1'b0;
        dur_reg            = '{15'd9000, 15'd4500, 15'd2250, 15'd560, 15'd1690, 15'd560};
        tol_reg            = 7'd25;
        cap_count          = 0;
        cap_bits           = '0;
        cap_failed         = 1'b0;
        cap_repeat         = 1'b0;
        error_count        = 0;
        no_gaps            = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_captures();
        test_default_frames();
        test_setting_sweep();
        test_ambiguous_space();
        test_noise_items();
        test_hold_for_results();
        test_random_captures();

        settle_decoder();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("nec_ir_frame_decoder_top test passed");
        else
            $display("nec_ir_frame_decoder_top test failed");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("nec_ir_frame_decoder_top test failed");
        $finish;
    end

endmodule
